// File: hdl/mstm_pkg.sv
// ----------------------------------------------------------------------------
// mstm_pkg: shared types and constants of the software timer manager
// Operation codes, sequencer states and limits used by the timer table.
// ----------------------------------------------------------------------------
package mstm_pkg;

   localparam int unsigned OP_W = 3;

   localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
   localparam logic [OP_W-1:0] OP_CREATE = 3'd1;
   localparam logic [OP_W-1:0] OP_START  = 3'd2;
   localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd4;
   localparam logic [OP_W-1:0] OP_CHANGE = 3'd5;

   localparam int unsigned ID_W     = 4;
   localparam int unsigned PERIOD_W = 32;
   localparam int unsigned TIME_W   = 64;
   localparam int unsigned STAMP_W  = 32;

   // expiries reported per tick at most
   localparam int unsigned    ROUND_W     = 5;
   localparam logic [ROUND_W-1:0] MAX_REPORTS = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMD,
      ST_ROUND,
      ST_SCAN,
      ST_PICK,
      ST_ARM,
      ST_FINISH,
      ST_EMIT
   } state_type;

endpackage

// File: hdl/mstm_ram.sv
// ----------------------------------------------------------------------------
// mstm_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mstm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/multi_slot_software_timer_manager.sv
// ----------------------------------------------------------------------------
// multi_slot_software_timer_manager: table of software timer slots
// Commands create, start, stop, delete or re-period a slot; a tick item
// advances time and reports the expired slots in order of expiry.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command or tick item; it is taken when req_valid is
//   high and req_stall low. req_stall is high while an item is in work.
//   rsp_* carries one expired slot per item; rsp_last marks the final
//   expiry of a tick. Commands and ticks with nothing expired give none.
// Operation:
//   Start and a period change of an active slot arm the slot. Every
//   selection round of a tick walks all slots through the single read port
//   of the slot RAMs, comparing one slot a cycle, and one 64-bit adder
//   serves time advance, arming and periodic re-arming. Each expiry is
//   shown one round after it is found, so rsp_last is known.
// Reset:
//   Synchronous, active high. Time, the insert counter, all active and
//   valid bits and the output valid flag are cleared; slot RAMs are not.
// Stall:
//   The result sits in an output register; while rsp_stall is high the
//   sequencer waits before loading the next expiry and holds the payload.
// ----------------------------------------------------------------------------
module multi_slot_software_timer_manager #(
   parameter int unsigned TIMER_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [3:0]  req_timer_id,
   input  logic [31:0] req_value,
   input  logic        req_periodic,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_expired_id,
   output logic        rsp_last
);

   localparam int unsigned SLOT_W = $clog2(TIMER_SLOTS);
   localparam int unsigned CNT_W  = $clog2(TIMER_SLOTS + 1);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TIMER_SLOTS);

   mstm_pkg::state_type state_ff, state_in;

   // captured item
   logic [mstm_pkg::OP_W-1:0]     op_ff, op_in;
   logic [mstm_pkg::ID_W-1:0]     id_ff, id_in;
   logic [mstm_pkg::PERIOD_W-1:0] value_ff, value_in;
   logic                          periodic_ff, periodic_in;

   logic [mstm_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [mstm_pkg::STAMP_W-1:0]  insert_cnt_ff, insert_cnt_in;
   logic [TIMER_SLOTS-1:0]        active_ff, active_in;
   logic [TIMER_SLOTS-1:0]        valid_ff, valid_in;

   // selection round
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [mstm_pkg::ROUND_W-1:0]  rounds_ff, rounds_in;
   logic                          found_ff, found_in;
   logic [mstm_pkg::TIME_W-1:0]   best_exp_ff, best_exp_in;
   logic [mstm_pkg::STAMP_W-1:0]  best_stamp_ff, best_stamp_in;
   logic [SLOT_W-1:0]             best_idx_ff, best_idx_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]             pend_id_ff, pend_id_in;
   logic                          emit_last_ff, emit_last_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mstm_pkg::ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                          rsp_last_ff, rsp_last_in;

   // RAM ports
   logic [SLOT_W-1:0]             rd_addr;
   logic [SLOT_W-1:0]             wr_addr;
   logic                          period_we;
   logic                          periodic_we;
   logic                          expiry_we;
   logic                          stamp_we;
   logic [mstm_pkg::PERIOD_W-1:0] period_wdata;
   logic [mstm_pkg::PERIOD_W-1:0] period_rd;
   logic [mstm_pkg::TIME_W-1:0]   expiry_rd;
   logic                          periodic_rd;
   logic [mstm_pkg::STAMP_W-1:0]  stamp_rd;

   // shared adder
   logic [mstm_pkg::TIME_W-1:0]   add_a;
   logic [mstm_pkg::PERIOD_W-1:0] add_b;
   logic [mstm_pkg::TIME_W-1:0]   add_sum;

   logic                          is_tick;
   logic [SLOT_W-1:0]             id_idx;
   logic                          id_in_range;
   logic                          id_ok;
   logic                          id_active;
   logic [mstm_pkg::PERIOD_W-1:0] value_clamped;
   logic [CNT_W-1:0]              cnt_m1;
   logic [SLOT_W-1:0]             eval_idx;
   logic                          scan_done;
   logic                          cand;
   logic                          out_free;

   assign is_tick       = (op_ff == mstm_pkg::OP_TICK);
   assign id_idx        = SLOT_W'(id_ff);
   assign id_in_range   = (32'(id_ff) < 32'(TIMER_SLOTS));
   assign id_ok         = id_in_range && valid_ff[id_idx];
   assign id_active     = id_in_range && active_ff[id_idx];
   assign value_clamped = (value_ff == '0) ? 32'd1 : value_ff;
   assign cnt_m1        = cnt_ff - CNT_W'(1);
   assign eval_idx      = cnt_m1[SLOT_W-1:0];
   assign scan_done     = (cnt_ff == SCAN_END);
   assign out_free      = !rsp_valid_ff || !rsp_stall;

   // slot is a better expired candidate than the one held
   assign cand = (cnt_ff != '0) && active_ff[eval_idx] && (expiry_rd <= now_ff) &&
                 (!found_ff || (expiry_rd < best_exp_ff) ||
                  ((expiry_rd == best_exp_ff) && (stamp_rd < best_stamp_ff)));

   always_comb begin
      add_a = now_ff;
      add_b = period_rd;
      if (state_ff == mstm_pkg::ST_CMD) begin
         add_b = 32'd1;
      end else if (is_tick) begin
         // periodic re-arm from the theoretical expiry
         add_a = best_exp_ff;
      end else if (op_ff == mstm_pkg::OP_CHANGE) begin
         add_b = value_clamped;
      end
   end

   assign add_sum = add_a + 64'(add_b);

   always_comb begin
      priority if (state_ff == mstm_pkg::ST_CMD) begin
         rd_addr = id_idx;
      end else if (state_ff == mstm_pkg::ST_PICK) begin
         rd_addr = best_idx_ff;
      end else if (scan_done) begin
         rd_addr = '0;
      end else begin
         rd_addr = cnt_ff[SLOT_W-1:0];
      end
   end

   assign wr_addr = (state_ff == mstm_pkg::ST_ARM && is_tick) ? best_idx_ff : id_idx;

   mstm_ram #(.WIDTH(mstm_pkg::PERIOD_W), .DEPTH(TIMER_SLOTS)) u_period_ram (
      .clock   (clock),
      .wr_en   (period_we),
      .wr_addr (wr_addr),
      .wr_data (period_wdata),
      .rd_addr (rd_addr),
      .rd_data (period_rd)
   );

   mstm_ram #(.WIDTH(mstm_pkg::TIME_W), .DEPTH(TIMER_SLOTS)) u_expiry_ram (
      .clock   (clock),
      .wr_en   (expiry_we),
      .wr_addr (wr_addr),
      .wr_data (add_sum),
      .rd_addr (rd_addr),
      .rd_data (expiry_rd)
   );

   mstm_ram #(.WIDTH(1), .DEPTH(TIMER_SLOTS)) u_periodic_ram (
      .clock   (clock),
      .wr_en   (periodic_we),
      .wr_addr (wr_addr),
      .wr_data (periodic_ff),
      .rd_addr (rd_addr),
      .rd_data (periodic_rd)
   );

   mstm_ram #(.WIDTH(mstm_pkg::STAMP_W), .DEPTH(TIMER_SLOTS)) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_we),
      .wr_addr (wr_addr),
      .wr_data (insert_cnt_ff),
      .rd_addr (rd_addr),
      .rd_data (stamp_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mstm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = mstm_pkg::ST_CMD;
            end
         end
         mstm_pkg::ST_CMD: begin
            priority if (is_tick) begin
               state_in = mstm_pkg::ST_ROUND;
            end else if (op_ff == mstm_pkg::OP_START && id_ok) begin
               state_in = mstm_pkg::ST_ARM;
            end else if (op_ff == mstm_pkg::OP_CHANGE && id_ok && id_active) begin
               state_in = mstm_pkg::ST_ARM;
            end else begin
               state_in = mstm_pkg::ST_IDLE;
            end
         end
         mstm_pkg::ST_ROUND: begin
            state_in = (rounds_ff == mstm_pkg::MAX_REPORTS) ? mstm_pkg::ST_FINISH
                                                           : mstm_pkg::ST_SCAN;
         end
         mstm_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = mstm_pkg::ST_PICK;
            end
         end
         mstm_pkg::ST_PICK: begin
            state_in = found_ff ? mstm_pkg::ST_ARM : mstm_pkg::ST_FINISH;
         end
         mstm_pkg::ST_ARM: begin
            priority if (!is_tick) begin
               state_in = mstm_pkg::ST_IDLE;
            end else if (pend_valid_ff) begin
               state_in = mstm_pkg::ST_EMIT;
            end else begin
               state_in = mstm_pkg::ST_ROUND;
            end
         end
         mstm_pkg::ST_FINISH: begin
            state_in = pend_valid_ff ? mstm_pkg::ST_EMIT : mstm_pkg::ST_IDLE;
         end
         mstm_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = emit_last_ff ? mstm_pkg::ST_IDLE : mstm_pkg::ST_ROUND;
            end
         end
         default: begin
            state_in = mstm_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in         = op_ff;
      id_in         = id_ff;
      value_in      = value_ff;
      periodic_in   = periodic_ff;
      now_in        = now_ff;
      insert_cnt_in = insert_cnt_ff;
      active_in     = active_ff;
      valid_in      = valid_ff;
      cnt_in        = cnt_ff;
      rounds_in     = rounds_ff;
      found_in      = found_ff;
      best_exp_in   = best_exp_ff;
      best_stamp_in = best_stamp_ff;
      best_idx_in   = best_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      emit_last_in  = emit_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      period_we     = 1'b0;
      periodic_we   = 1'b0;
      expiry_we     = 1'b0;
      stamp_we      = 1'b0;
      period_wdata  = value_clamped;

      unique case (state_ff)
         mstm_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in       = req_op;
               id_in       = req_timer_id;
               value_in    = req_value;
               periodic_in = req_periodic;
            end
         end
         mstm_pkg::ST_CMD: begin
            unique case (op_ff)
               mstm_pkg::OP_TICK: begin
                  now_in        = add_sum;
                  rounds_in     = '0;
                  pend_valid_in = 1'b0;
               end
               mstm_pkg::OP_CREATE: begin
                  if (id_in_range) begin
                     period_we         = 1'b1;
                     periodic_we       = 1'b1;
                     active_in[id_idx] = 1'b0;
                     valid_in[id_idx]  = 1'b1;
                  end
               end
               mstm_pkg::OP_START, mstm_pkg::OP_STOP: begin
                  if (id_ok) begin
                     active_in[id_idx] = 1'b0;
                  end
               end
               mstm_pkg::OP_DELETE: begin
                  if (id_ok) begin
                     active_in[id_idx] = 1'b0;
                     valid_in[id_idx]  = 1'b0;
                  end
               end
               mstm_pkg::OP_CHANGE: begin
                  if (id_ok) begin
                     period_we         = 1'b1;
                     active_in[id_idx] = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         mstm_pkg::ST_ROUND: begin
            cnt_in   = '0;
            found_in = 1'b0;
         end
         mstm_pkg::ST_SCAN: begin
            if (!scan_done) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (cand) begin
               found_in      = 1'b1;
               best_exp_in   = expiry_rd;
               best_stamp_in = stamp_rd;
               best_idx_in   = eval_idx;
            end
         end
         mstm_pkg::ST_PICK: begin
            if (found_ff) begin
               active_in[best_idx_ff] = 1'b0;
            end
         end
         mstm_pkg::ST_ARM: begin
            if (is_tick) begin
               rounds_in = rounds_ff + mstm_pkg::ROUND_W'(1);
               if (periodic_rd) begin
                  expiry_we              = 1'b1;
                  stamp_we               = 1'b1;
                  insert_cnt_in          = insert_cnt_ff + 32'd1;
                  active_in[best_idx_ff] = 1'b1;
               end
               if (pend_valid_ff) begin
                  emit_last_in = 1'b0;
               end else begin
                  pend_id_in    = best_idx_ff;
                  pend_valid_in = 1'b1;
               end
            end else begin
               expiry_we         = 1'b1;
               stamp_we          = 1'b1;
               insert_cnt_in     = insert_cnt_ff + 32'd1;
               active_in[id_idx] = 1'b1;
            end
         end
         mstm_pkg::ST_FINISH: begin
            emit_last_in = 1'b1;
         end
         mstm_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = mstm_pkg::ID_W'(pend_id_ff);
               rsp_last_in  = emit_last_ff;
               if (emit_last_ff) begin
                  pend_valid_in = 1'b0;
               end else begin
                  // hold the newest expiry until the next round decides last
                  pend_id_in = best_idx_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mstm_pkg::ST_IDLE;
         now_ff        <= '0;
         insert_cnt_ff <= '0;
         active_ff     <= '0;
         valid_ff      <= '0;
         cnt_ff        <= '0;
         rounds_ff     <= '0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         emit_last_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         insert_cnt_ff <= insert_cnt_in;
         active_ff     <= active_in;
         valid_ff      <= valid_in;
         cnt_ff        <= cnt_in;
         rounds_ff     <= rounds_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         emit_last_ff  <= emit_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      value_ff      <= value_in;
      periodic_ff   <= periodic_in;
      best_exp_ff   <= best_exp_in;
      best_stamp_ff <= best_stamp_in;
      best_idx_ff   <= best_idx_in;
      pend_id_ff    <= pend_id_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall      = (state_ff != mstm_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_expired_id = rsp_id_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_active_is_valid: assert property (@(posedge clock) disable iff (reset)
      (active_ff & ~valid_ff) == '0)
      else $error("active slot that is not valid");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == mstm_pkg::ST_EMIT))
      else $error("result raised outside emit");

   a_emit_has_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == mstm_pkg::ST_EMIT |-> pend_valid_ff)
      else $error("emit without a pending expiry");

   a_rounds_bound: assert property (@(posedge clock) disable iff (reset)
      rounds_ff <= mstm_pkg::MAX_REPORTS)
      else $error("too many expiries in one tick");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= SCAN_END)
      else $error("scan counter past the table");

   a_accept_to_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == mstm_pkg::ST_CMD)
      else $error("accepted item not decoded");
`endif

endmodule
